// ===== hw/rtl/trht_pkg.sv =====
`timescale 1ns / 1ps

package trht_pkg;

  // Command codes carried in tuser of the input stream
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_WIN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_REGIONS    = 2'd2;

  // Width or height code that stretches an edge to the window edge
  localparam logic signed [15:0] FULL_DIM = -16'sd1000;

  typedef struct packed {
    logic signed [15:0] depth;
    logic signed [15:0] height;
    logic signed [15:0] width;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } region_t;

  typedef struct packed {
    logic               vld;
    logic               hit;
    logic signed [15:0] depth;
  } match_t;

endpackage

// ===== hw/rtl/trht_ram.sv =====
`timescale 1ns / 1ps

module trht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/trht_match.sv =====
`timescale 1ns / 1ps

module trht_match #(
  parameter int unsigned AW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [AW-1:0]         idx_i,
  input  trht_pkg::region_t     entry_i,
  input  logic [14:0]           win_width_i,
  input  logic [14:0]           win_height_i,
  input  logic signed [15:0]    ptr_x_i,
  input  logic signed [15:0]    ptr_y_i,
  output trht_pkg::match_t      match_o,
  output logic [AW-1:0]         idx_o
);

  import trht_pkg::*;

  logic signed [16:0] right_d, bottom_d;
  logic signed [16:0] left_q, top_q, right_q, bottom_q;
  logic signed [15:0] depth_q;
  logic [AW-1:0]      idx_q;
  logic               vld_q;
  logic signed [16:0] px, py;

  // Resolve the far edges at full precision
  always_comb begin
    if (entry_i.width == FULL_DIM) begin
      right_d = signed'({2'b00, win_width_i});
    end else begin
      right_d = {entry_i.left[15], entry_i.left} + {entry_i.width[15], entry_i.width};
    end
    if (entry_i.height == FULL_DIM) begin
      bottom_d = signed'({2'b00, win_height_i});
    end else begin
      bottom_d = {entry_i.top[15], entry_i.top} + {entry_i.height[15], entry_i.height};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q   <= {entry_i.left[15], entry_i.left};
    top_q    <= {entry_i.top[15], entry_i.top};
    right_q  <= right_d;
    bottom_q <= bottom_d;
    depth_q  <= entry_i.depth;
    idx_q    <= idx_i;
  end

  assign px = {ptr_x_i[15], ptr_x_i};
  assign py = {ptr_y_i[15], ptr_y_i};

  // Edges count as inside
  assign match_o.vld   = vld_q;
  assign match_o.hit   = (px >= left_q) && (px <= right_q) && (py >= top_q) && (py <= bottom_q);
  assign match_o.depth = depth_q;
  assign idx_o         = idx_q;

endmodule

// ===== hw/rtl/topmost_region_hit_test_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tuser: command; tdata: slot, rectangle, depth, pointer
// m_axis    out        tuser: hit_found; tdata: hit_index
// cfg       in         cfg_index_i selects window width, window height, regions in use
//
// A write word is taken while idle and its empty result is registered at once.
// A query scans min(regions_in_use, MAX_REGIONS) entries, or none: the single read
// port of the region RAM supplies one entry per cycle, then the RAM read register,
// the compare stage, end detection and the result register follow in turn. Reset
// clears control state only; the RAM holds no reset and starts without a clearing
// pass. Input is held off while a query runs or while a result waits that would be
// overwritten.
module topmost_region_hit_test_core #(
  parameter int unsigned MAX_REGIONS = 16,
  localparam int unsigned AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] entry_index, [19:4] rect_left, [35:20] rect_top, [51:36] rect_width,
  // [67:52] rect_height, [83:68] stack_depth, [99:84] pointer_x,
  // [115:100] pointer_y, [119:116] zero
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tuser,  // [0] command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,  // [3:0] hit_index, [7:4] zero
  output logic         m_axis_tuser,  // [0] hit_found
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [14:0]  cfg_data_i
);

  import trht_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e             state_q;
  logic [14:0]        win_width_q, win_height_q;
  logic [4:0]         regions_q;
  logic [CW-1:0]      cnt_d, cnt_q, issue_q;
  logic signed [15:0] ptr_x_q, ptr_y_q;
  logic               rd_vld_q;
  logic [AW-1:0]      rd_idx_q;
  logic               found_q;
  logic [AW-1:0]      best_idx_q;
  logic signed [15:0] best_depth_q;
  logic               out_valid_q, out_found_q;
  logic [3:0]         out_index_q;

  logic               in_acc, out_acc, out_free, out_load;
  logic               rd_en, wr_en, scan_done, take;
  logic [AW-1:0]      rd_addr;
  region_t            wr_entry, rd_entry;
  match_t             match;
  logic [AW-1:0]      match_idx;

  assign cfg_ready_o   = 1'b1;
  assign out_acc       = out_valid_q && m_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = ((state_q == ST_IDLE) && in_acc && (s_axis_tuser == CMD_WRITE)) ||
                         ((state_q == ST_FINISH) && out_free);

  assign wr_entry.left   = s_axis_tdata[19:4];
  assign wr_entry.top    = s_axis_tdata[35:20];
  assign wr_entry.width  = s_axis_tdata[51:36];
  assign wr_entry.height = s_axis_tdata[67:52];
  assign wr_entry.depth  = s_axis_tdata[83:68];

  // Drop writes to slots beyond the table
  assign wr_en = in_acc && (s_axis_tuser == CMD_WRITE) &&
                 (32'(s_axis_tdata[3:0]) < 32'(MAX_REGIONS));

  always_comb begin
    if (32'(regions_q) > 32'(MAX_REGIONS)) begin
      cnt_d = CW'(MAX_REGIONS);
    end else begin
      cnt_d = CW'(regions_q);
    end
  end

  assign rd_en     = (state_q == ST_SCAN) && (issue_q < cnt_q);
  assign rd_addr   = AW'(issue_q);
  assign scan_done = (state_q == ST_SCAN) && (issue_q == cnt_q) && !rd_vld_q && !match.vld;
  // First entry wins on a tie
  assign take      = match.vld && match.hit && (!found_q || (match.depth > best_depth_q));

  trht_ram #(
    .WIDTH ($bits(region_t)),
    .DEPTH (MAX_REGIONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(s_axis_tdata[3:0])),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  trht_match #(
    .AW (AW)
  ) u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vld_i        (rd_vld_q),
    .idx_i        (rd_idx_q),
    .entry_i      (rd_entry),
    .win_width_i  (win_width_q),
    .win_height_i (win_height_q),
    .ptr_x_i      (ptr_x_q),
    .ptr_y_i      (ptr_y_q),
    .match_o      (match),
    .idx_o        (match_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      win_width_q  <= '0;
      win_height_q <= '0;
      regions_q    <= '0;
      cnt_q        <= '0;
      issue_q      <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_index_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WIN_WIDTH:  win_width_q  <= cfg_data_i;
          CFG_WIN_HEIGHT: win_height_q <= cfg_data_i;
          CFG_REGIONS:    regions_q    <= cfg_data_i[4:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end

      rd_vld_q <= rd_en;
      if (rd_en) begin
        issue_q <= issue_q + 1'b1;
      end
      if (take) begin
        found_q <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == CMD_QUERY) begin
              cnt_q   <= cnt_d;
              issue_q <= '0;
              found_q <= 1'b0;
              state_q <= ST_SCAN;
            end else begin
              out_found_q <= 1'b0;
              out_index_q <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_found_q <= found_q;
            out_index_q <= found_q ? 4'(best_idx_q) : 4'd0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ptr_x_q <= s_axis_tdata[99:84];
      ptr_y_q <= s_axis_tdata[115:100];
    end
    rd_idx_q <= rd_addr;
    if (take) begin
      best_idx_q   <= match_idx;
      best_depth_q <= match.depth;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {4'd0, out_index_q};

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input accepted during a scan");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser == CMD_WRITE)) |=> (m_axis_tvalid && !m_axis_tuser))
    else $error("write word gave no empty result");

  a_miss_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'd0))
    else $error("miss carries a non-zero index");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (issue_q <= cnt_q))
    else $error("scan read beyond the regions in use");

endmodule

// ===== dv/topmost_region_hit_test_core_test.sv =====
`timescale 1ns / 1ps

module topmost_region_hit_test_core_test;
  import trht_pkg::*;

  localparam int unsigned NUM_SLOTS   = 16;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          PHASE_WORDS = 155;
  localparam int          NUM_PHASES  = 10;

  typedef struct packed {
    logic       found;
    logic [3:0] slot;
  } hit_t;

  // Mirror of the region table and window registers; predicts the pick for every word.
  class hit_scoreboard;
    region_t     regions_q[NUM_SLOTS];
    logic [14:0] win_width;
    logic [14:0] win_height;
    logic [4:0]  regions_used;
    hit_t        pending_hits[$];
    int          mismatches;
    int          queries;
    int          hits;

    function new();
      win_width    = '0;
      win_height   = '0;
      regions_used = '0;
      mismatches   = 0;
      queries      = 0;
      hits         = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [14:0] value);
      case (idx)
        CFG_WIN_WIDTH:  win_width = value;
        CFG_WIN_HEIGHT: win_height = value;
        CFG_REGIONS:    regions_used = value[4:0];
        default: ;
      endcase
    endfunction

    function int scan_count();
      return (regions_used > NUM_SLOTS) ? NUM_SLOTS : int'(regions_used);
    endfunction

    // Edges at full precision; a full-dimension code snaps to the window edge.
    function void region_edges(int i, output int l, output int r, output int t,
                               output int b);
      l = $signed(regions_q[i].left);
      t = $signed(regions_q[i].top);
      if (regions_q[i].width == FULL_DIM) r = int'(win_width);
      else r = l + $signed(regions_q[i].width);
      if (regions_q[i].height == FULL_DIM) b = int'(win_height);
      else b = t + $signed(regions_q[i].height);
    endfunction

    function hit_t topmost_hit(int px, int py);
      hit_t pick;
      int   l, r, t, b, d, best_depth;
      pick       = '0;
      best_depth = 0;
      for (int i = 0; i < scan_count(); i++) begin
        region_edges(i, l, r, t, b);
        d = $signed(regions_q[i].depth);
        if (px >= l && px <= r && py >= t && py <= b) begin
          // strict compare keeps the lowest slot on a tie
          if (!pick.found || d > best_depth) begin
            pick.found = 1'b1;
            pick.slot  = i[3:0];
            best_depth = d;
          end
        end
      end
      return pick;
    endfunction

    function void note_word(logic cmd, logic [119:0] word);
      if (cmd == CMD_WRITE) begin
        regions_q[word[3:0]] = word[83:4];
        pending_hits.push_back('0);
      end else begin
        queries++;
        pending_hits.push_back(topmost_hit($signed(word[99:84]), $signed(word[115:100])));
        if (pending_hits[$].found) hits++;
      end
    endfunction

    function void check_result(logic found, logic [7:0] word);
      hit_t want;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result word: found=%0b index=%0d", $time, found,
                   word[3:0]);
        return;
      end
      want = pending_hits.pop_front();
      if (found !== want.found || word[3:0] !== want.slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                   $time, want.found, want.slot, found, word[3:0]);
      end
    endfunction

    function int pending();
      return pending_hits.size();
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         s_axis_tuser = CMD_WRITE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = CFG_WIN_WIDTH;
  logic [14:0]  cfg_data_i = '0;

  hit_scoreboard sb = new();
  bit            quiet = 1'b0;
  int            words_sent = 0;
  int            settings = 0;
  int            cycle_count = 0;
  int            errors;

  topmost_region_hit_test_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [119:0] pack_word(logic [3:0] slot, region_t r, logic [15:0] px,
                                             logic [15:0] py);
    return {4'b0, py, px, r.depth, r.height, r.width, r.top, r.left, slot};
  endfunction

  function automatic region_t mk_region(int l, int t, int w, int h, int d);
    region_t r;
    r.left   = l[15:0];
    r.top    = t[15:0];
    r.width  = w[15:0];
    r.height = h[15:0];
    r.depth  = d[15:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_pos();
    int v;
    if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 65535);
    else v = int'($urandom_range(0, 220)) - 60;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_size();
    int v;
    case ($urandom_range(0, 7))
      0: v = $signed(FULL_DIM);
      1: v = $urandom_range(0, 65535);
      2: v = -int'($urandom_range(1, 20));
      default: v = $urandom_range(0, 90);
    endcase
    return v[15:0];
  endfunction

  function automatic region_t random_region();
    region_t r;
    int      d;
    r.left   = pick_pos();
    r.top    = pick_pos();
    r.width  = pick_size();
    r.height = pick_size();
    case ($urandom_range(0, 5))
      0: d = $urandom_range(0, 65535);
      1: d = -32768;
      2: d = 32767;
      default: d = int'($urandom_range(0, 4)) - 2;
    endcase
    r.depth = d[15:0];
    return r;
  endfunction

  // Land near an edge most of the time so hits and edge cases are common.
  function automatic logic [15:0] pick_coord(int lo, int hi);
    int v;
    case ($urandom_range(0, 5))
      0: v = lo;
      1: v = hi;
      2: v = lo - 1;
      3: v = hi + 1;
      4: v = (hi >= lo) ? lo + int'($urandom_range(0, hi - lo)) : hi;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic send_word(input logic cmd, input logic [119:0] word);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(cmd, word);
    words_sent++;
  endtask

  task automatic write_slot(input int slot, input region_t r);
    send_word(CMD_WRITE, pack_word(slot[3:0], r, 16'h8000, 16'h7fff));
  endtask

  task automatic query_at(input int px, input int py);
    send_word(CMD_QUERY, pack_word(4'hf, '1, px[15:0], py[15:0]));
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_window(input int w, input int h, input int n);
    logic [1:0]  idx [3];
    logic [14:0] val [3];
    idx = '{CFG_WIN_WIDTH, CFG_WIN_HEIGHT, CFG_REGIONS};
    val = '{w[14:0], h[14:0], n[14:0]};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic random_word();
    logic        cmd;
    logic [15:0] px, py;
    int          k, l, r, t, b;
    cmd = ($urandom_range(0, 9) < 6) ? CMD_QUERY : CMD_WRITE;
    px  = 16'($urandom_range(0, 65535));
    py  = 16'($urandom_range(0, 65535));
    if (cmd == CMD_QUERY && $urandom_range(0, 7) != 0) begin
      k = $urandom_range(0, NUM_SLOTS - 1);
      if (sb.scan_count() > 0) k = k % sb.scan_count();
      sb.region_edges(k, l, r, t, b);
      px = pick_coord(l, r);
      py = pick_coord(t, b);
    end
    send_word(cmd, pack_word(4'($urandom_range(0, 15)), random_region(), px, py));
  endtask

  // Result side: random stall before each word, sometimes none at all.
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of regions in use scans nothing.
    query_at(-32768, 32767);

    // Fill every slot before any query scans it.
    write_slot(0, mk_region(0, 0, -1000, -1000, -32768));
    write_slot(1, mk_region(-32768, -32768, 32767, 32767, 32767));
    write_slot(2, mk_region(32767, 32767, 32767, 32767, 0));
    write_slot(3, mk_region(20, 10, -32768, -32768, 100));
    write_slot(4, mk_region(10, 10, 20, 20, 5));
    write_slot(5, mk_region(10, 10, 20, 20, 5));
    write_slot(6, mk_region(25, 25, 0, 0, 5));
    write_slot(7, mk_region(-5, -5, -1000, -1000, -1));
    for (int i = 8; i < NUM_SLOTS; i++) write_slot(i, mk_region(40 + i, 30, 5, 5, i - 12));
    drain();
    set_window(100, 50, 16);
    query_at(0, 0);
    query_at(25, 25);
    query_at(100, 50);
    query_at(101, 50);
    query_at(-32768, -32768);
    query_at(32767, 32767);
    query_at(-6, -6);
    query_at(30, 30);
    drain();
    set_window(32767, 32767, 31);
    query_at(32767, 32767);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_window(32767, 32767, 16);
        1: set_window(0, 0, 16);
        2: set_window($urandom_range(0, 200), $urandom_range(0, 200), 0);
        3: set_window($urandom_range(0, 200), $urandom_range(0, 200), 1);
        4: set_window($urandom_range(0, 200), $urandom_range(0, 200), 31);
        5: set_window($urandom_range(0, 32767), $urandom_range(0, 32767), 16);
        default: set_window($urandom_range(0, 200), $urandom_range(0, 200),
                            $urandom_range(1, 16));
      endcase
      quiet = (p % 3 == 1);
      for (int i = 0; i < PHASE_WORDS; i++) random_word();
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("Sent %0d words under %0d window settings: %0d position queries, %0d hits.",
             words_sent, settings, sb.queries, sb.hits);
    errors = sb.mismatches + sb.pending();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
